### sv/table_linear_interpolation_unit_macros.svh
// assertion macros for the table linear interpolation unit
`ifndef TABLE_LINEAR_INTERPOLATION_UNIT_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define TLI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define TLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TLI_ASSERT_IMPL(lbl, ante, cons)
`define TLI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/tli_pkg.sv
// shared types and constants of the table linear interpolation unit
package tli_pkg;

    localparam int TABLE_DEPTH   = 16;
    localparam int KEY_W         = 16;
    localparam int VAL_W         = 16;
    localparam int ENTRY_INDEX_W = 4;
    localparam int ENTRY_COUNT_W = 5;
    localparam int STATUS_W      = 2;

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int DIVCNT_W = $clog2(VAL_W);
    localparam int PROD_W   = KEY_W + VAL_W;

    localparam int S_TDATA_W = ((ENTRY_INDEX_W + KEY_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAL_W + 7) / 8) * 8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH  = 2'd0,
        ST_INTERP = 2'd1,
        ST_OUT    = 2'd2
    } status_t;

    // datapath operation selected by one microcode word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SCAN,
        OP_DECIDE,
        OP_MUL,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_FINISH,
        OP_WRITE
    } op_t;

    // jump condition of one microcode word
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_QUERY,
        JC_SCAN_MORE,
        JC_NO_INTERP,
        JC_DIV_MORE,
        JC_OUT_BUSY
    } jc_t;

    // datapath flags tested by the sequencer
    typedef struct packed {
        logic no_query;
        logic scan_more;
        logic no_interp;
        logic div_more;
        logic out_busy;
    } cond_t;

endpackage

### sv/table_linear_interpolation_unit.sv
// Piecewise linear interpolation lookup table. Loads (s_tuser = 0) write one
// key/value slot each, giving no result. A query (s_tuser = 1) scans the
// first entry_count slots (at most 16) through the single read port of the table
// memory, one slot a cycle, then answers with the matched value, the value
// interpolated on the first bracketing pair, or zero with out-of-range status.
// Interpolation runs a multiply and a bit-serial divider, one quotient bit a
// cycle. The result waits in an output register, and the next item is taken
// while it waits.
module table_linear_interpolation_unit
    import tli_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [ENTRY_COUNT_W-1:0] cfg_wr_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_W-1:0]     s_tdata,   // entry_index, key, value, zero fill
    input  logic                     s_tuser,   // command
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,   // result_value
    output logic [STATUS_W-1:0]      m_tuser    // status
);

    op_t              op;
    cond_t            cond;
    logic [VAL_W-1:0] res;

    tli_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .op      (op)
    );

    tli_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .cond        (cond),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_index    (s_tdata[ENTRY_INDEX_W-1:0]),
        .in_key      (s_tdata[ENTRY_INDEX_W+KEY_W-1:ENTRY_INDEX_W]),
        .in_value    (s_tdata[ENTRY_INDEX_W+KEY_W+VAL_W-1:ENTRY_INDEX_W+KEY_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res),
        .out_status  (m_tuser)
    );

    assign m_tdata = M_TDATA_W'(res);

endmodule

### sv/tli_sequencer.sv
// microcode sequencer: step counter, control rom and conditional jumps
module tli_sequencer
    import tli_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cond_t cond,
    output op_t   op
);

    localparam int UPC_W = 4;

    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        op_t  op;
        jc_t  jc;
        upc_t target;
    } ucode_t;

    localparam upc_t STEP_WAIT   = 4'd0;
    localparam upc_t STEP_SCAN   = 4'd1;
    localparam upc_t STEP_DECIDE = 4'd2;
    localparam upc_t STEP_MUL    = 4'd3;
    localparam upc_t STEP_DIVLD  = 4'd4;
    localparam upc_t STEP_DIV    = 4'd5;
    localparam upc_t STEP_FINISH = 4'd6;
    localparam upc_t STEP_WRITE  = 4'd7;
    localparam upc_t STEP_DONE   = 4'd8;

    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        case (addr)
            STEP_WAIT:   w = '{OP_ACCEPT,   JC_NO_QUERY,  STEP_WAIT};
            STEP_SCAN:   w = '{OP_SCAN,     JC_SCAN_MORE, STEP_SCAN};
            STEP_DECIDE: w = '{OP_DECIDE,   JC_NO_INTERP, STEP_WRITE};
            STEP_MUL:    w = '{OP_MUL,      JC_NEVER,     STEP_WAIT};
            STEP_DIVLD:  w = '{OP_DIV_LOAD, JC_NEVER,     STEP_WAIT};
            STEP_DIV:    w = '{OP_DIV_STEP, JC_DIV_MORE,  STEP_DIV};
            STEP_FINISH: w = '{OP_FINISH,   JC_NEVER,     STEP_WAIT};
            STEP_WRITE:  w = '{OP_WRITE,    JC_OUT_BUSY,  STEP_WRITE};
            STEP_DONE:   w = '{OP_NOP,      JC_ALWAYS,    STEP_WAIT};
            default:     w = '{OP_NOP,      JC_ALWAYS,    STEP_WAIT};
        endcase
        return w;
    endfunction

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t word;
    logic   take_jump;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

    always_comb begin
        word = ucode_rom(upc_reg);
        case (word.jc)
            JC_NEVER:     take_jump = 1'b0;
            JC_ALWAYS:    take_jump = 1'b1;
            JC_NO_QUERY:  take_jump = cond.no_query;
            JC_SCAN_MORE: take_jump = cond.scan_more;
            JC_NO_INTERP: take_jump = cond.no_interp;
            JC_DIV_MORE:  take_jump = cond.div_more;
            JC_OUT_BUSY:  take_jump = cond.out_busy;
            default:      take_jump = 1'b1;
        endcase
        upc_next = take_jump ? word.target : upc_reg + 1'b1;
        op       = word.op;
    end

endmodule

### sv/tli_datapath.sv
// table memories, scan registers, multiplier, serial divider and output register
`include "table_linear_interpolation_unit_macros.svh"

module tli_datapath
    import tli_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  op_t                      op,
    output cond_t                    cond,
    input  logic                     cfg_wr_en,
    input  logic [ENTRY_COUNT_W-1:0] cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_cmd,
    input  logic [ENTRY_INDEX_W-1:0] in_index,
    input  logic [KEY_W-1:0]         in_key,
    input  logic [VAL_W-1:0]         in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VAL_W-1:0]         out_res,
    output logic [STATUS_W-1:0]      out_status
);

    logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] val_mem [TABLE_DEPTH];

    logic [ENTRY_COUNT_W-1:0] count_reg;
    logic                     out_valid_reg;
    logic                     rd_valid_reg;
    logic                     first_reg;
    logic                     hit_reg;
    logic                     found_reg;

    logic [CNT_W-1:0]    idx_reg;
    logic [DIVCNT_W-1:0] div_cnt_reg;

    logic signed [KEY_W-1:0] b_reg;
    logic signed [KEY_W-1:0] rd_key_reg;
    logic signed [VAL_W-1:0] rd_val_reg;
    logic signed [KEY_W-1:0] key0_reg;
    logic signed [KEY_W-1:0] prev_key_reg;
    logic signed [VAL_W-1:0] prev_val_reg;
    logic signed [KEY_W-1:0] a_reg;
    logic signed [KEY_W-1:0] c_reg;
    logic signed [VAL_W-1:0] fa_reg;
    logic signed [VAL_W-1:0] fc_reg;
    logic signed [VAL_W-1:0] res_reg;
    status_t                 status_reg;

    logic              neg_reg;
    logic [VAL_W-1:0]  mag_reg;
    logic [KEY_W-1:0]  dsub_reg;
    logic [KEY_W-1:0]  den_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KEY_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  quo_reg;

    logic [VAL_W-1:0]    out_res_reg;
    status_t             out_status_reg;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] n_used;
    logic             read_more;
    logic             interp_ok;
    logic [KEY_W:0]   dsub_wide;
    logic [KEY_W:0]   den_wide;
    logic [VAL_W:0]   diff_wide;
    logic [VAL_W:0]   mag_wide;
    logic [KEY_W:0]   rem_shift;
    logic             rem_ge;
    logic [KEY_W:0]   rem_sub;

    assign in_ready = (op == OP_ACCEPT);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        if (int'(count_reg) > TABLE_DEPTH) begin
            n_used = CNT_W'(TABLE_DEPTH);
        end else begin
            n_used = CNT_W'(count_reg);
        end
    end

    assign read_more = (idx_reg < n_used);
    // the scan only yields a pair when the keys around the query are in order
    assign interp_ok = !hit_reg && found_reg && (b_reg > key0_reg) && (b_reg < prev_key_reg);

    assign dsub_wide = {b_reg[KEY_W-1], b_reg} - {a_reg[KEY_W-1], a_reg};
    assign den_wide  = {c_reg[KEY_W-1], c_reg} - {a_reg[KEY_W-1], a_reg};
    assign diff_wide = {fc_reg[VAL_W-1], fc_reg} - {fa_reg[VAL_W-1], fa_reg};
    assign mag_wide  = diff_wide[VAL_W] ? (~diff_wide + 1'b1) : diff_wide;

    // restoring step, quotient bits shift in where the dividend bits leave
    assign rem_shift = {rem_reg, quo_reg[VAL_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    assign cond.no_query  = !(accept && (in_cmd == CMD_QUERY));
    assign cond.scan_more = read_more;
    assign cond.no_interp = !interp_ok;
    assign cond.div_more  = (div_cnt_reg != DIVCNT_W'(VAL_W - 1));
    assign cond.out_busy  = !out_free;

    // table memories
    always_ff @(posedge aclk) begin
        if (accept && (in_cmd == CMD_LOAD) && (int'(in_index) < TABLE_DEPTH)) begin
            key_mem[IDX_W'(in_index)] <= in_key;
            val_mem[IDX_W'(in_index)] <= in_value;
        end
        if ((op == OP_SCAN) && read_more) begin
            rd_key_reg <= key_mem[idx_reg[IDX_W-1:0]];
            rd_val_reg <= val_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            first_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if ((op == OP_WRITE) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_ACCEPT: begin
                    rd_valid_reg <= 1'b0;
                    first_reg    <= 1'b1;
                    hit_reg      <= 1'b0;
                    found_reg    <= 1'b0;
                    idx_reg      <= '0;
                end
                OP_SCAN: begin
                    rd_valid_reg <= read_more;
                    if (read_more) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rd_valid_reg) begin
                        first_reg <= 1'b0;
                        if (rd_key_reg == b_reg) begin
                            hit_reg <= 1'b1;
                        end
                        if (!first_reg && !found_reg && (prev_key_reg < b_reg) &&
                            (rd_key_reg > b_reg)) begin
                            found_reg <= 1'b1;
                        end
                    end
                end
                OP_DIV_LOAD: div_cnt_reg <= '0;
                OP_DIV_STEP: div_cnt_reg <= div_cnt_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_ACCEPT: begin
                b_reg <= in_key;
            end
            OP_SCAN: begin
                if (rd_valid_reg) begin
                    prev_key_reg <= rd_key_reg;
                    prev_val_reg <= rd_val_reg;
                    if (first_reg) begin
                        key0_reg <= rd_key_reg;
                    end
                    // later slots win on duplicate keys
                    if (rd_key_reg == b_reg) begin
                        res_reg <= rd_val_reg;
                    end
                    if (!first_reg && !found_reg && (prev_key_reg < b_reg) &&
                        (rd_key_reg > b_reg)) begin
                        a_reg  <= prev_key_reg;
                        fa_reg <= prev_val_reg;
                        c_reg  <= rd_key_reg;
                        fc_reg <= rd_val_reg;
                    end
                end
            end
            OP_DECIDE: begin
                neg_reg  <= diff_wide[VAL_W];
                mag_reg  <= mag_wide[VAL_W-1:0];
                dsub_reg <= dsub_wide[KEY_W-1:0];
                den_reg  <= den_wide[KEY_W-1:0];
                if (hit_reg) begin
                    status_reg <= ST_MATCH;
                end else if (interp_ok) begin
                    status_reg <= ST_INTERP;
                end else begin
                    status_reg <= ST_OUT;
                    res_reg    <= '0;
                end
            end
            OP_MUL: begin
                prod_reg <= mag_reg * dsub_reg;
            end
            OP_DIV_LOAD: begin
                // quotient stays below the magnitude, so the high part is below the divisor
                rem_reg <= prod_reg[PROD_W-1:VAL_W];
                quo_reg <= prod_reg[VAL_W-1:0];
            end
            OP_DIV_STEP: begin
                rem_reg <= rem_ge ? rem_sub[KEY_W-1:0] : rem_shift[KEY_W-1:0];
                quo_reg <= {quo_reg[VAL_W-2:0], rem_ge};
            end
            OP_FINISH: begin
                res_reg <= neg_reg ? (fa_reg - $signed(quo_reg)) : (fa_reg + $signed(quo_reg));
            end
            OP_WRITE: begin
                if (out_free) begin
                    out_res_reg    <= res_reg;
                    out_status_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;
    assign out_status = out_status_reg;

    `TLI_ASSERT_IMPL(a_out_range_zero, out_valid_reg && (out_status_reg == ST_OUT), out_res_reg == '0)
    `TLI_ASSERT_NEXT(a_write_shows, (op == OP_WRITE) && out_free, out_valid_reg)
    `TLI_ASSERT_IMPL(a_rem_below_den, op == OP_DIV_STEP, rem_reg < den_reg)
    `TLI_ASSERT_NEXT(a_interp_bounded, op == OP_FINISH, ((res_reg >= fa_reg) && (res_reg <= fc_reg)) || ((res_reg <= fa_reg) && (res_reg >= fc_reg)))

endmodule

### bench/tb_top.sv
// self-checking bench for the table linear interpolation unit with an item-level predictor
module tb_top
    import tli_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 48;
    localparam int RUN_LIMIT_NS  = 8_000_000;
    localparam int PHASE_ITEMS   = 460;

    typedef struct {
        logic [VAL_W-1:0] value;
        status_t          status;
    } lookup_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [ENTRY_COUNT_W-1:0] cfg_wr_data;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata;   // entry_index, key, value, zero fill
    logic                     s_tuser;   // command
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_W-1:0]     m_tdata;   // result_value
    logic [STATUS_W-1:0]      m_tuser;   // status

    // predictor copy of the table and the entry count
    logic signed [KEY_W-1:0]  lut_keys   [TABLE_DEPTH];
    logic signed [VAL_W-1:0]  lut_values [TABLE_DEPTH];
    logic [ENTRY_COUNT_W-1:0] lut_count;

    lookup_result_t expected_lookups[$];
    int mismatch_count;
    int items_sent;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_cycles;

    table_linear_interpolation_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #4 aclk = ~aclk;

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        lookup_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result value %0d status %0d", $time,
                         $signed(m_tdata[VAL_W-1:0]), m_tuser);
                mismatch_count++;
            end else begin
                exp_res = expected_lookups.pop_front();
                if (m_tdata[VAL_W-1:0] !== exp_res.value) begin
                    $display("%0t: result_value expected %0d got %0d", $time,
                             $signed(exp_res.value), $signed(m_tdata[VAL_W-1:0]));
                    mismatch_count++;
                end
                if (m_tuser !== exp_res.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             exp_res.status, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // exact match (last slot wins), else first bracketing pair, else out of range
    function automatic lookup_result_t interpolate_lookup(logic signed [KEY_W-1:0] qkey);
        lookup_result_t r;
        int     n;
        logic   hit;
        logic   done;
        int     a;
        int     c;
        int     fa;
        int     fc;
        int     diff;
        longint q;
        r.value  = '0;
        r.status = ST_OUT;
        n    = (lut_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(lut_count);
        hit  = 1'b0;
        done = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (lut_keys[i] == qkey) begin
                r.value = lut_values[i];
                hit = 1'b1;
            end
        end
        if (hit) begin
            r.status = ST_MATCH;
        end else if (n >= 2 && qkey > lut_keys[0] && qkey < lut_keys[n-1]) begin
            for (int i = 0; i + 1 < n; i++) begin
                a = lut_keys[i];
                c = lut_keys[i+1];
                if (!done && a < int'(qkey) && c > int'(qkey)) begin
                    fa   = lut_values[i];
                    fc   = lut_values[i+1];
                    diff = fc - fa;
                    q = (longint'(diff < 0 ? -diff : diff) * longint'(int'(qkey) - a))
                        / longint'(c - a);
                    r.value  = (diff < 0) ? VAL_W'(longint'(fa) - q) : VAL_W'(longint'(fa) + q);
                    r.status = ST_INTERP;
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] clamp_key(int k);
        if (k > 32767)
            return 16'sh7fff;
        if (k < -32768)
            return 16'sh8000;
        return KEY_W'(k);
    endfunction

    // query keys that land on, between and around the used entries
    function automatic logic signed [KEY_W-1:0] pick_query_key();
        int n;
        int i;
        int lo;
        int hi;
        int sel;
        n   = (lut_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(lut_count);
        sel = $urandom_range(0, 9);
        if (sel <= 2 && n > 0)
            return lut_keys[$urandom_range(0, n - 1)];
        if (sel <= 6 && n >= 2) begin
            i  = $urandom_range(0, n - 2);
            lo = lut_keys[i];
            hi = lut_keys[i+1];
            if (lo < hi)
                return KEY_W'(lo + int'($urandom_range(0, hi - lo)));
        end
        if (sel == 7 && n > 0) begin
            if ($urandom_range(0, 1))
                return clamp_key(int'(lut_keys[0]) - int'($urandom_range(1, 3)));
            return clamp_key(int'(lut_keys[n-1]) + int'($urandom_range(1, 3)));
        end
        if (sel == 9)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return KEY_W'($urandom);
    endfunction

    // drives one item and leaves valid high unless the sender idles afterwards
    task automatic send_item(input logic cmd, input logic [ENTRY_INDEX_W-1:0] slot,
                             input logic signed [KEY_W-1:0] key,
                             input logic signed [VAL_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({val, key, slot});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (cmd == CMD_LOAD) begin
            lut_keys[slot]   = key;
            lut_values[slot] = val;
        end else begin
            expected_lookups.insert(expected_lookups.size(), interpolate_lookup(key));
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic send_query(input logic signed [KEY_W-1:0] key);
        send_item(CMD_QUERY, ENTRY_INDEX_W'($urandom), key, VAL_W'($urandom));
    endtask

    // a load may still be in flight after the last result, so settle before returning
    task automatic wait_idle();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_lookups.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_entry_count(input logic [ENTRY_COUNT_W-1:0] cnt);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(posedge aclk);
        lut_count = cnt;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_query(16'sh0000);
    endtask

    task automatic test_directed_table();
        logic signed [KEY_W-1:0] k;
        logic signed [VAL_W-1:0] v;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (i)
                0:  begin k = 16'sh8000; v = 16'sh7fff; end
                1:  begin k = -16'sd256; v = 16'sh8000; end
                2:  begin k = 16'sh0000; v = 16'sd4096; end
                3:  begin k = 16'sh0000; v = -16'sd4096; end  // duplicate key
                15: begin k = 16'sh7fff; v = 16'sh8000; end
                default: begin
                    k = KEY_W'((i - 3) * 2048);
                    v = (i % 2) ? 16'sh5555 : 16'shaaaa;
                end
            endcase
            send_item(CMD_LOAD, ENTRY_INDEX_W'(i), k, v);
        end
        wait_idle();
        write_entry_count(ENTRY_COUNT_W'(TABLE_DEPTH));
        send_query(16'sh8000);
        send_query(16'sh7fff);
        send_query(16'sh0000);
        send_query(-16'sd16384);
        send_query(16'sd30000);
    endtask

    task automatic test_count_limits();
        wait_idle();
        write_entry_count('1);  // beyond depth, clamps to the full table
        send_query(-16'sd1);
        wait_idle();
        write_entry_count(ENTRY_COUNT_W'(1));  // one entry cannot interpolate
        send_query(16'sh8000);
        send_query(16'sd100);
    endtask

    task automatic random_round(output int sent);
        logic signed [KEY_W-1:0]  keys [TABLE_DEPTH];
        logic [ENTRY_COUNT_W-1:0] cnt;
        int mode;
        int acc;
        int n_q;
        int first_slot;
        int s;
        case ($urandom_range(0, 9))
            0:       cnt = '0;
            1:       cnt = ENTRY_COUNT_W'(1);
            2:       cnt = ENTRY_COUNT_W'(2);
            3:       cnt = ENTRY_COUNT_W'(TABLE_DEPTH);
            4:       cnt = ENTRY_COUNT_W'($urandom_range(TABLE_DEPTH + 1, 31));
            default: cnt = ENTRY_COUNT_W'($urandom_range(2, TABLE_DEPTH));
        endcase
        wait_idle();
        write_entry_count(cnt);
        mode = $urandom_range(0, 3);
        case (mode)
            0:       acc = int'($urandom_range(0, 8191)) - 32768;
            default: acc = int'($urandom_range(0, 65535)) - 32768;
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (mode)
                0: begin keys[i] = clamp_key(acc); acc += $urandom_range(0, 4096); end
                1: begin keys[i] = clamp_key(acc); acc += $urandom_range(1, 64); end
                2: begin keys[i] = clamp_key(acc); acc += $urandom_range(0, 3); end
                default: keys[i] = KEY_W'($urandom);  // unordered table
            endcase
        end
        first_slot = $urandom_range(0, TABLE_DEPTH - 1);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            s = (first_slot + i) % TABLE_DEPTH;
            send_item(CMD_LOAD, ENTRY_INDEX_W'(s), keys[s], VAL_W'($urandom));
        end
        n_q = $urandom_range(24, 48);
        for (int i = 0; i < n_q; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_LOAD, ENTRY_INDEX_W'($urandom), KEY_W'($urandom),
                          VAL_W'($urandom));
            else
                send_query(pick_query_key());
        end
        sent = TABLE_DEPTH + n_q;
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        int done;
        int sent;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        done = 0;
        while (done < PHASE_ITEMS) begin
            random_round(sent);
            done += sent;
        end
    endtask

    // output held off long enough to fill the block, then a full drain mid-stream
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_idle();
        write_entry_count(ENTRY_COUNT_W'(TABLE_DEPTH));
        rx_hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_query(pick_query_key());
        wait_idle();
        for (int i = 0; i < 20; i++)
            send_query(pick_query_key());
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_LOAD;
        m_tready       = 1'b0;
        lut_count      = '0;
        mismatch_count = 0;
        items_sent     = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            lut_keys[i]   = '0;
            lut_values[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_directed_table();
        test_count_limits();
        test_random_phase(0, 0);
        test_random_phase(57, 0);
        test_random_phase(0, 57);
        test_random_phase(22, 22);
        test_backpressure();

        wait_idle();
        if (expected_lookups.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_lookups.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
